### rtl/lkv_pkg.sv
// Package for the LRU key-value cache: payload word types, field widths,
// command codes and the miss value. No dependencies.
`default_nettype none

package lkv_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                    kind;
    logic [KEY_W-1:0]        lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic [KEY_W-1:0]        evicted_key;
  } result_t;

endpackage

`default_nettype wire

### rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: sequencer, valid bits and entry RAM.
// Depends on lkv_pkg and lkv_ram.
`default_nettype none

// A get or put word is taken when start is high and busy is low. The block
// sweeps the entry RAM once to search keys, find the least recent entry and
// the first free slot, one RAM read per cycle, then strobes result_valid for
// one cycle with the result word; the receiver has no way to stall it. A get
// miss ends there. A hit or a put then needs a second read-modify-write sweep
// of the RAM to age recency ranks and write the entry; busy stays high until
// that sweep ends. max_entries is to be written only while busy is low; the
// block itself does not enforce this. 0 acts as 1 and values above ENTRIES
// act as ENTRIES.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire lkv_pkg::cmd_t              cmd,
  input  wire logic                       cfg_we,
  input  wire logic [lkv_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                            result_valid,
  output lkv_pkg::result_t                result
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [RW-1:0]           rank;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DECIDE = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  max_entries;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [IW:0]       cnt;
  logic              p_vld;
  logic [IW-1:0]     p_idx;
  cmd_t              req;

  logic                    found;
  logic [IW-1:0]           f_idx;
  logic [RW-1:0]           f_rank;
  logic signed [VAL_W-1:0] f_value;
  logic                    vic_found;
  logic [IW-1:0]           vic_idx;
  logic [RW-1:0]           vic_rank;
  logic [KEY_W-1:0]        vic_key;
  logic                    free_found;
  logic [IW-1:0]           free_idx;
  logic                    ins_mode;
  logic [IW-1:0]           slot;

  logic              issue;
  logic [IW-1:0]     raddr;
  logic              ram_we;
  entry_t            wentry;
  entry_t            rentry;
  logic              last;
  logic              scan;
  logic              match_take;
  logic              vic_take;
  logic              free_take;
  logic [LW-1:0]     lim;
  logic              put_miss;
  logic              evict;
  logic              have_slot;
  logic [IW-1:0]     slot_d;

  lkv_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_idx),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  assign busy  = (state != S_IDLE);
  assign issue = ((state == S_SEARCH) || (state == S_UPDATE)) &&
                 (cnt < (IW + 1)'(ENTRIES));
  assign raddr = cnt[IW-1:0];
  assign last  = p_vld && (p_idx == IW'(ENTRIES - 1));

  assign scan       = (state == S_SEARCH) && p_vld;
  assign match_take = scan && valid[p_idx] && (rentry.key == req.lookup_key);
  assign vic_take   = scan && valid[p_idx] && (!vic_found || (rentry.rank > vic_rank));
  assign free_take  = scan && !valid[p_idx] && !free_found;

  always_comb begin
    if (max_entries == '0) begin
      lim = LW'(1);
    end else if (LW'(max_entries) > LW'(ENTRIES)) begin
      lim = LW'(ENTRIES);
    end else begin
      lim = LW'(max_entries);
    end
  end

  assign put_miss  = (req.kind == KIND_PUT) && !found;
  assign evict     = put_miss && (LW'(count) >= lim) && vic_found;
  assign have_slot = put_miss && (free_found || evict);
  assign slot_d    = (evict && (!free_found || (vic_idx < free_idx))) ? vic_idx : free_idx;

  always_comb begin
    count_next = count;
    if (state == S_DECIDE) begin
      count_next = count - CW'(evict) + CW'(have_slot);
    end
  end

  // rank aging and slot fill, one entry per cycle behind the read
  always_comb begin
    ram_we = 1'b0;
    wentry = rentry;
    if ((state == S_UPDATE) && p_vld) begin
      if (ins_mode) begin
        if (p_idx == slot) begin
          ram_we       = 1'b1;
          wentry.key   = req.lookup_key;
          wentry.value = req.write_value;
          wentry.rank  = '0;
        end else if (valid[p_idx]) begin
          ram_we      = 1'b1;
          wentry.rank = RW'(rentry.rank + 1'b1);
        end
      end else begin
        if (p_idx == f_idx) begin
          ram_we      = 1'b1;
          wentry.rank = '0;
          if (req.kind == KIND_PUT) begin
            wentry.value = req.write_value;
          end
        end else if (valid[p_idx] && (rentry.rank < f_rank)) begin
          ram_we      = 1'b1;
          wentry.rank = RW'(rentry.rank + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_entries  <= CFG_W'(16);
      valid        <= '0;
      count        <= '0;
      cnt          <= '0;
      p_vld        <= 1'b0;
      found        <= 1'b0;
      vic_found    <= 1'b0;
      free_found   <= 1'b0;
      ins_mode     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_DECIDE);
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state      <= S_SEARCH;
            cnt        <= '0;
            p_vld      <= 1'b0;
            found      <= 1'b0;
            vic_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_SEARCH: begin
          cnt   <= cnt + (IW + 1)'(issue);
          p_vld <= issue;
          if (match_take) begin
            found <= 1'b1;
          end
          if (vic_take) begin
            vic_found <= 1'b1;
          end
          if (free_take) begin
            free_found <= 1'b1;
          end
          if (last) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // victim slot reused for the new key stays valid
          if (evict && (slot_d != vic_idx)) begin
            valid[vic_idx] <= 1'b0;
          end
          if (have_slot) begin
            valid[slot_d] <= 1'b1;
          end
          count    <= count_next;
          ins_mode <= put_miss;
          cnt      <= '0;
          p_vld    <= 1'b0;
          if ((req.kind == KIND_GET) && !found) begin
            state <= S_IDLE;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          cnt   <= cnt + (IW + 1)'(issue);
          p_vld <= issue;
          if (last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= cmd;
    end
    p_idx <= raddr;
    if (match_take) begin
      f_idx   <= p_idx;
      f_rank  <= rentry.rank;
      f_value <= rentry.value;
    end
    if (vic_take) begin
      vic_idx  <= p_idx;
      vic_rank <= rentry.rank;
      vic_key  <= rentry.key;
    end
    if (free_take) begin
      free_idx <= p_idx;
    end
    if (state == S_DECIDE) begin
      slot               <= slot_d;
      result.hit         <= found;
      result.read_value  <= (req.kind == KIND_PUT) ? '0 : (found ? f_value : MISS_VALUE);
      result.evicted     <= evict;
      result.evicted_key <= evict ? vic_key : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/lkv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
